>>> rtl/polyline_delta_decoder_assert.svh
// Assertion macros shared by the checker of the polyline delta decoder.
// Each macro clocks on the rising edge and is disabled while reset is low.
`ifndef POLYLINE_DELTA_DECODER_ASSERT_SVH
`define POLYLINE_DELTA_DECODER_ASSERT_SVH

// Same-cycle implication
`define PDD_ASSERT_IMPLY(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("polyline delta decoder: same-cycle check failed");

// Next-cycle implication
`define PDD_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("polyline delta decoder: next-cycle check failed");

`endif

>>> rtl/pdd_pkg.sv
// Package of the polyline delta decoder: widths, status codes and the
// structs passed between the front end, the accumulator and the output queue.
package pdd_pkg;

	localparam int MAX_DIMS   = 16;
	localparam int DIM_W      = 4;
	localparam int CNT_W      = 5;
	localparam int PV_W       = 60;
	localparam int COORD_W    = 64;
	localparam int GC_W       = 4;
	localparam int OUTQ_DEPTH = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;

	localparam logic [7:0]      CHAR_BIAS  = 8'd63;
	localparam logic [GC_W-1:0] MAX_GROUPS = 4'd12;

	// Result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_CHAR   = 3'd1;
	localparam logic [2:0] ST_OVERFLOW   = 3'd2;
	localparam logic [2:0] ST_TRUNCATED  = 3'd3;
	localparam logic [2:0] ST_INCOMPLETE = 3'd4;

	// Request from the character front end to the accumulator
	typedef struct packed {
		logic               valid;
		logic               mem_op;
		logic               clear;
		logic [COORD_W-1:0] delta;
		logic [DIM_W-1:0]   dim;
		logic [2:0]         status;
		logic               last;
	} pdd_req_t;

	// One result item
	typedef struct packed {
		logic [COORD_W-1:0] coordinate;
		logic [DIM_W-1:0]   dim_index;
		logic [2:0]         status;
		logic               last;
	} pdd_res_t;

endpackage

>>> rtl/pdd_front.sv
// Character front end: assembles 5-bit groups, checks errors, undoes zigzag
// and walks the dimension index. Depends on pdd_pkg.
module pdd_front import pdd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       code_char,
	input  logic             stream_end,
	input  logic [CNT_W-1:0] dim_count,
	output pdd_req_t         req
);

	logic [PV_W-1:0]  pv_q, pv_nxt, pv_new;
	logic [GC_W-1:0]  gc_q, gc_nxt;
	logic [DIM_W-1:0] cur_dim_q, cur_dim_nxt;
	logic             dropping_q, dropping_nxt;

	logic [7:0]         gsum;
	logic [4:0]         g5;
	logic               cont, bad, ovf, wrap;
	logic [5:0]         sh;
	logic [COORD_W-1:0] v64, delta;
	logic [CNT_W-1:0]   eff_dims, next_dim;

	// Decode one character
	always_comb begin
		gsum   = code_char - CHAR_BIAS;
		g5     = gsum[4:0];
		cont   = (gsum[7:5] != 3'd0);
		bad    = (code_char < CHAR_BIAS);
		ovf    = (gc_q >= MAX_GROUPS);
		sh     = {gc_q, 2'b00} + {2'b00, gc_q};
		pv_new = pv_q | (PV_W'(g5) << sh);
		v64    = {{(COORD_W-PV_W){1'b0}}, pv_new};
		delta  = pv_new[0] ? ~(v64 >> 1) : (v64 >> 1);
		if (dim_count == '0) begin
			eff_dims = CNT_W'(1);
		end else if (dim_count > CNT_W'(MAX_DIMS)) begin
			eff_dims = CNT_W'(MAX_DIMS);
		end else begin
			eff_dims = dim_count;
		end
		next_dim = {1'b0, cur_dim_q} + CNT_W'(1);
		wrap     = (next_dim >= eff_dims);
	end

	// Next state and request
	always_comb begin
		req          = '0;
		pv_nxt       = pv_q;
		gc_nxt       = gc_q;
		cur_dim_nxt  = cur_dim_q;
		dropping_nxt = dropping_q;
		if (fire) begin
			if (dropping_q) begin
				if (stream_end) begin
					dropping_nxt = 1'b0;
					req.clear    = 1'b1;
				end
			end else if (bad || ovf) begin
				req.valid    = 1'b1;
				req.status   = bad ? ST_BAD_CHAR : ST_OVERFLOW;
				req.last     = 1'b1;
				req.clear    = 1'b1;
				dropping_nxt = !stream_end;
			end else if (cont) begin
				if (stream_end) begin
					req.valid  = 1'b1;
					req.status = ST_TRUNCATED;
					req.last   = 1'b1;
					req.clear  = 1'b1;
				end else begin
					pv_nxt = pv_new;
					gc_nxt = gc_q + GC_W'(1);
				end
			end else begin
				req.valid  = 1'b1;
				req.mem_op = 1'b1;
				req.delta  = delta;
				req.dim    = cur_dim_q;
				req.last   = stream_end;
				req.status = (stream_end && !wrap) ? ST_INCOMPLETE : ST_OK;
				req.clear  = stream_end;
				pv_nxt     = '0;
				gc_nxt     = '0;
				cur_dim_nxt = wrap ? '0 : next_dim[DIM_W-1:0];
			end
			// Restart the value state at a stream boundary
			if (req.clear) begin
				pv_nxt      = '0;
				gc_nxt      = '0;
				cur_dim_nxt = '0;
			end
		end
	end

	// Hold the value state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q       <= '0;
			gc_q       <= '0;
			cur_dim_q  <= '0;
			dropping_q <= 1'b0;
		end else begin
			pv_q       <= pv_nxt;
			gc_q       <= gc_nxt;
			cur_dim_q  <= cur_dim_nxt;
			dropping_q <= dropping_nxt;
		end
	end

endmodule

>>> rtl/pdd_accum.sv
// Running-total accumulator: a 16-entry synchronous memory read at accept,
// added and written back from stage 1, with forwarding. Depends on pdd_pkg.
module pdd_accum import pdd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  pdd_req_t req,
	output logic     res_valid,
	output pdd_res_t res
);

	logic [COORD_W-1:0] mem [MAX_DIMS];
	logic [COORD_W-1:0] rdata_s1;
	logic [MAX_DIMS-1:0] tot_vld_q;

	logic               valid_s1, mem_op_s1, last_s1, tot_vld_s1;
	logic [COORD_W-1:0] delta_s1;
	logic [DIM_W-1:0]   dim_s1;
	logic [2:0]         status_s1;

	logic               fwd_vld_q;
	logic [DIM_W-1:0]   fwd_dim_q;
	logic [COORD_W-1:0] fwd_total_q;

	logic [COORD_W-1:0] base, total;
	logic               keep;

	// Read the total at accept, write the new total back from stage 1
	always_ff @(posedge clk) begin
		if (req.mem_op) begin
			rdata_s1 <= mem[req.dim];
		end
		if (valid_s1 && mem_op_s1) begin
			mem[dim_s1] <= total;
		end
	end

	// Advance the request into stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		mem_op_s1  <= req.mem_op;
		last_s1    <= req.last;
		delta_s1   <= req.delta;
		dim_s1     <= req.dim;
		status_s1  <= req.status;
		tot_vld_s1 <= tot_vld_q[req.dim];
	end

	// Add the delta, forwarding the write of the cycle in which the read ran
	always_comb begin
		if (fwd_vld_q && (fwd_dim_q == dim_s1)) begin
			base = fwd_total_q;
		end else if (tot_vld_s1) begin
			base = rdata_s1;
		end else begin
			base = '0;
		end
		total = base + delta_s1;
		keep  = valid_s1 && mem_op_s1 && !last_s1;
	end

	// Track which totals belong to the current stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_vld_q <= '0;
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= keep;
			if (req.clear) begin
				tot_vld_q <= '0;
			end else if (keep) begin
				tot_vld_q[dim_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_dim_q   <= dim_s1;
		fwd_total_q <= total;
	end

	assign res_valid      = valid_s1;
	assign res.coordinate = mem_op_s1 ? total : '0;
	assign res.dim_index  = mem_op_s1 ? dim_s1 : '0;
	assign res.status     = status_s1;
	assign res.last       = last_s1;

endmodule

>>> rtl/pdd_outq.sv
// Output queue of result items between the accumulator and the master side.
// Depends on pdd_pkg.
module pdd_outq import pdd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pdd_res_t          push_data,
	input  logic              pop,
	output logic              not_empty,
	output pdd_res_t          head,
	output logic [QCNT_W-1:0] count
);

	pdd_res_t            slots_q [OUTQ_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];
	assign count     = count_q;

endmodule

>>> rtl/polyline_delta_decoder.sv
// Polyline delta decoder, top level. A result goes through accumulator stage 1
// and the output queue to m_tvalid. Throughput: one byte per cycle while the
// queue has room, set by the read-add-write loop on the running-total memory,
// closed by forwarding. Reset (async, low) clears control state and the total
// valid bits; total memory contents stay undefined and need no clearing pass.
module polyline_delta_decoder import pdd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// slave side; s_tdata: code_char[7:0]; s_tlast: stream_end
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	// master side; m_tdata: coordinate[63:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,
	// m_tuser: dim_index[3:0], status[6:4], zero pad[7]
	output logic [7:0]  m_tuser,
	// m_tlast: last_of_stream
	output logic        m_tlast,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [CNT_W-1:0]  dim_count_q;
	logic              fire, res_valid, pop;
	logic [QCNT_W-1:0] q_count;
	pdd_req_t          req;
	pdd_res_t          res, head;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= CNT_W'(1);
		end else if (psel && penable && pwrite && !paddr[2]) begin
			dim_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, dim_count_q};

	// Accept while the queue can take this item and the one in stage 1
	assign s_tready = (({1'b0, q_count} + (QCNT_W+1)'(res_valid)) < (QCNT_W+1)'(OUTQ_DEPTH));
	assign fire     = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;

	pdd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.code_char  (s_tdata),
		.stream_end (s_tlast),
		.dim_count  (dim_count_q),
		.req        (req)
	);

	pdd_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res       (res)
	);

	pdd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (pop),
		.not_empty (m_tvalid),
		.head      (head),
		.count     (q_count)
	);

	assign m_tdata = head.coordinate;
	assign m_tuser = {1'b0, head.status, head.dim_index};
	assign m_tlast = head.last;

endmodule

>>> rtl/pdd_checker.sv
// Port-level checker of the polyline delta decoder and its bind.
// Depends on pdd_pkg and polyline_delta_decoder_assert.svh.
`include "polyline_delta_decoder_assert.svh"

module pdd_checker import pdd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [7:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled result item holds
	`PDD_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	// Any non-ok status ends the stream
	`PDD_ASSERT_IMPLY(a_err_last, clk, arst_n, m_tvalid && (m_tuser[6:4] != ST_OK), m_tlast)
	// Error results carry no coordinate
	`PDD_ASSERT_IMPLY(a_err_zero, clk, arst_n, m_tvalid && (m_tuser[6:4] == ST_BAD_CHAR || m_tuser[6:4] == ST_OVERFLOW || m_tuser[6:4] == ST_TRUNCATED), (m_tdata == 64'd0) && (m_tuser[3:0] == 4'd0))
	// Status stays in its code range and the pad bit stays low
	`PDD_ASSERT_IMPLY(a_status_rng, clk, arst_n, m_tvalid, (m_tuser[6:4] <= ST_INCOMPLETE) && !m_tuser[7])

endmodule

bind polyline_delta_decoder pdd_checker u_pdd_checker (.*);

>>> sim/tb_polyline_delta_decoder.sv
// Self-checking testbench for polyline_delta_decoder: directed items, then random streams.
// Expected results come from a predictor that runs on every accepted item.
// Depends on pdd_pkg and the decoder RTL only.
module tb_polyline_delta_decoder;
	timeunit 1ns;
	timeprecision 1ps;
	import pdd_pkg::*;

	localparam logic [2:0] ADDR_DIM_COUNT = 3'd0;
	localparam int N_DIRECTED  = 24;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 60;
	localparam int WIDE_PHASE  = 3;

	// One directed item: optional register write before it, the item, and the
	// typed-in result where it is fixed by the special case
	typedef struct packed {
		logic       cfg;
		logic [4:0] dims;
		logic [7:0] ch;
		logic       fin;
		logic       fixed;
		pdd_res_t   res;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
		// zero delta, then a one-group value of -1 that closes the stream
		'{1'b0, 5'd0, 8'd63,  1'b0, 1'b1, '{64'd0, 4'd0, ST_OK, 1'b0}},
		'{1'b0, 5'd0, 8'd64,  1'b1, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, ST_OK, 1'b1}},
		// bad character mid-stream, the rest of the stream is dropped
		'{1'b0, 5'd0, 8'd0,   1'b0, 1'b1, '{64'd0, 4'd0, ST_BAD_CHAR, 1'b1}},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd62,  1'b1, 1'b0, '0},
		// bad character on the last item of a stream
		'{1'b0, 5'd0, 8'd62,  1'b1, 1'b1, '{64'd0, 4'd0, ST_BAD_CHAR, 1'b1}},
		// value cut off by the end of the stream
		'{1'b0, 5'd0, 8'd127, 1'b1, 1'b1, '{64'd0, 4'd0, ST_TRUNCATED, 1'b1}},
		// twelve groups are taken, the thirteenth overflows
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd255, 1'b0, 1'b1, '{64'd0, 4'd0, ST_OVERFLOW, 1'b1}},
		'{1'b0, 5'd0, 8'd94,  1'b1, 1'b0, '0},
		// two dimensions: one full point, then the stream ends mid-point
		'{1'b1, 5'd2, 8'd65,  1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd66,  1'b0, 1'b0, '0},
		'{1'b0, 5'd0, 8'd67,  1'b1, 1'b1, '{64'd3, 4'd0, ST_INCOMPLETE, 1'b1}}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // code_char[7:0]
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // coordinate[63:0]
	logic [7:0]  m_tuser;   // dim_index[3:0], status[6:4], zero pad[7]
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state
	logic [4:0]         dim_count_reg;
	logic [PV_W-1:0]    part_val;
	logic [GC_W-1:0]    grp_cnt;
	logic [COORD_W-1:0] dim_total [MAX_DIMS];
	logic [DIM_W-1:0]   cur_dim;
	logic               dropping;

	pdd_res_t expected_coords [$];
	int       mismatch_cnt;
	int       items_sent;
	int       stall_left;
	bit       idle_en;

	polyline_delta_decoder u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("** polyline_delta_decoder: FAILED **");
		$finish;
	end

	function automatic void clear_stream();
		part_val = '0;
		grp_cnt  = '0;
		cur_dim  = '0;
		foreach (dim_total[i])
			dim_total[i] = '0;
	endfunction

	// Append one expected result item at the tail
	function automatic void queue_result(input pdd_res_t res);
		expected_coords.insert(expected_coords.size(), res);
	endfunction

	// Out-of-range counts act as the nearest legal one
	function automatic int eff_dims();
		if (dim_count_reg == 0)
			return 1;
		if (dim_count_reg > MAX_DIMS)
			return MAX_DIMS;
		return int'(dim_count_reg);
	endfunction

	// Advance the decoder state by one accepted item, queue its result if any
	function automatic void decode_char(input logic [7:0] ch, input logic fin);
		logic [7:0]         grp;
		logic [COORD_W-1:0] raw;
		logic [COORD_W-1:0] delta;
		logic [COORD_W-1:0] total;
		int                 nxt;
		pdd_res_t           res;

		if (dropping) begin
			if (fin) begin
				dropping = 1'b0;
				clear_stream();
			end
			return;
		end
		// bad character wins over overflow
		if (ch < CHAR_BIAS || grp_cnt >= MAX_GROUPS) begin
			res = '{'0, '0, (ch < CHAR_BIAS) ? ST_BAD_CHAR : ST_OVERFLOW, 1'b1};
			queue_result(res);
			clear_stream();
			dropping = !fin;
			return;
		end
		grp = ch - CHAR_BIAS;
		part_val |= PV_W'(grp[4:0]) << (5 * grp_cnt);
		grp_cnt++;
		if (grp >= 8'h20) begin
			if (fin) begin
				res = '{'0, '0, ST_TRUNCATED, 1'b1};
				queue_result(res);
				clear_stream();
			end
			return;
		end
		// undo zigzag, accumulate with wrap
		raw   = COORD_W'(part_val);
		delta = raw[0] ? ~(raw >> 1) : (raw >> 1);
		total = dim_total[cur_dim] + delta;
		dim_total[cur_dim] = total;
		part_val = '0;
		grp_cnt  = '0;
		nxt = (int'(cur_dim) + 1 >= eff_dims()) ? 0 : int'(cur_dim) + 1;
		res.coordinate = total;
		res.dim_index  = cur_dim;
		res.status     = (fin && nxt != 0) ? ST_INCOMPLETE : ST_OK;
		res.last       = fin;
		cur_dim = DIM_W'(nxt);
		queue_result(res);
		if (fin)
			clear_stream();
	endfunction

	// Offer one item, with an optional gap first, and predict on acceptance
	task automatic send_char(input logic [7:0] ch, input logic fin);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		decode_char(ch, fin);
		items_sent++;
	endtask

	// Continuation groups then a closing group; wide values carry all-ones payload
	task automatic send_value(input int groups, input logic fin, input bit wide);
		for (int i = 0; i < groups - 1; i++)
			send_char(wide ? 8'(126 + 32 * $urandom_range(0, 4)) : 8'($urandom_range(95, 255)),
				1'b0);
		send_char(wide ? 8'd94 : 8'($urandom_range(63, 94)), fin);
	endtask

	// Drop valid and hold until every expected result is out and the pipe is empty
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_coords.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_dim_count(input logic [4:0] dims);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_DIM_COUNT;
		pwdata  <= {27'($urandom), dims};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		dim_count_reg = dims;
	endtask

	// Random streams of whole points, broken now and then; stop at the quota
	task automatic run_phase(input int quota, input bit wide);
		int   target;
		int   vals;
		int   n;
		logic fin;

		target = items_sent + quota;
		while (items_sent < target) begin
			vals = (wide ? 20 : $urandom_range(1, 4)) * eff_dims();
			for (int k = 0; k < vals && items_sent < target; k++) begin
				fin = (k == vals - 1);
				n = wide ? 12 : (($urandom_range(0, 7) == 0) ? 12 : $urandom_range(1, 4));
				case (wide ? 39 : $urandom_range(0, 39))
					0: send_char(8'($urandom_range(0, 62)), $urandom_range(0, 3) == 0);
					1: send_value(13, fin, 1'b0);
					2: send_char(8'($urandom_range(95, 255)), 1'b1);
					3: send_value(n, 1'b1, 1'b0);
					default: send_value(n, fin, wide);
				endcase
			end
		end
	endtask

	// Check each result against the oldest expectation, stall in bursts
	always @(posedge clk) begin
		pdd_res_t want;

		if (arst_n && m_tvalid && m_tready) begin
			if (expected_coords.size() == 0) begin
				$error("unexpected result: coordinate %h", m_tdata);
				mismatch_cnt++;
			end else begin
				want = expected_coords.pop_front();
				if (m_tdata !== want.coordinate) begin
					$error("coordinate: expected %h, got %h", want.coordinate, m_tdata);
					mismatch_cnt++;
				end
				if (m_tuser[3:0] !== want.dim_index) begin
					$error("dim_index: expected %0d, got %0d", want.dim_index, m_tuser[3:0]);
					mismatch_cnt++;
				end
				if (m_tuser[6:4] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser[6:4]);
					mismatch_cnt++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_stream: expected %0d, got %0d", want.last, m_tlast);
					mismatch_cnt++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			m_tready   <= 1'b0;
			stall_left = $urandom_range(0, 15);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		idle_en  = 1'b1;
		mismatch_cnt  = 0;
		items_sent    = 0;
		stall_left    = 0;
		dim_count_reg = 5'd1;
		dropping      = 1'b0;
		clear_stream();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items; fixed rows replace the predicted result with the typed one
		foreach (DIR_ROWS[r]) begin
			if (DIR_ROWS[r].cfg) begin
				wait_drained();
				write_dim_count(DIR_ROWS[r].dims);
			end
			send_char(DIR_ROWS[r].ch, DIR_ROWS[r].fin);
			if (DIR_ROWS[r].fixed)
				expected_coords[expected_coords.size() - 1] = DIR_ROWS[r].res;
		end

		// Random phases, each with its own dimension count; streams may span phases
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: write_dim_count(5'd16);
				1: write_dim_count(5'd0);
				2: write_dim_count(5'd31);
				WIDE_PHASE: write_dim_count(5'd1);
				4: write_dim_count(5'd17);
				5: write_dim_count(5'd2);
				default: write_dim_count(5'($urandom_range(0, 31)));
			endcase
			idle_en <= (p != 2) && (p < PHASES - 2);
			run_phase((p == WIDE_PHASE) ? 200 : PHASE_ITEMS, p == WIDE_PHASE);
		end

		wait_drained();
		if (mismatch_cnt == 0)
			$display("** polyline_delta_decoder: PASSED **");
		else
			$display("** polyline_delta_decoder: FAILED **");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/pdd_pkg.sv
rtl/pdd_front.sv
rtl/pdd_accum.sv
rtl/pdd_outq.sv
rtl/polyline_delta_decoder.sv
rtl/pdd_checker.sv
sim/tb_polyline_delta_decoder.sv
